### hdl/ilid_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilid_pkg
// Shared types and codes for the indexed list insert/delete unit.
// ----------------------------------------------------------------------------
package ilid_pkg;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_GET    = 2'd1,
      CMD_DELETE = 2'd2,
      CMD_CLEAR  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_FULL       = 2'd1,
      ST_BEYOND_CAP = 2'd2,
      ST_BEYOND_LEN = 2'd3
   } status_type;

   localparam int REQ_TDATA_BITS = 40;
   localparam int RSP_TDATA_BITS = 40;
   localparam int CSR_ADDR_BITS  = 3;
   localparam int CSR_DATA_BITS  = 32;
   localparam int LEN_BITS       = 5;
   localparam int POS_BITS       = 4;
   localparam int DATA_BITS      = 32;
   localparam int LEN_LIMIT      = 31;

   localparam logic [CSR_ADDR_BITS-1:0] CSR_CAPACITY_ADDR = 3'd0;
   localparam logic [LEN_BITS-1:0]      CAPACITY_RESET    = 5'd16;

   // Broadcast control from the command decode to every cell.
   typedef struct packed {
      logic                shift_up;
      logic                shift_down;
      logic [LEN_BITS-1:0] pos;
   } cell_ctl_type;

endpackage

### hdl/ilid_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilid_cell
// One list slot: holds a word, takes a neighbor's word or the new word on insert/delete.
// ----------------------------------------------------------------------------
module ilid_cell
   import ilid_pkg::*;
#(
   parameter int IDX = 0,
   parameter int SW  = 32
) (
   input  logic         clock,
   input  cell_ctl_type ctl,
   input  logic [SW-1:0] word_in,
   input  logic [SW-1:0] left_in,
   input  logic [SW-1:0] right_in,
   output logic [SW-1:0] entry_out,
   output logic [SW-1:0] read_out
);

   localparam logic [LEN_BITS-1:0] MY_IDX = LEN_BITS'(IDX);

   logic [SW-1:0] entry_ff;
   logic [SW-1:0] entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.shift_up) begin
         if (MY_IDX > ctl.pos) begin
            entry_in = left_in;
         end else if (MY_IDX == ctl.pos) begin
            entry_in = word_in;
         end
      end else if (ctl.shift_down && (MY_IDX >= ctl.pos)) begin
         entry_in = right_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_out = entry_ff;
   assign read_out  = (MY_IDX == ctl.pos) ? entry_ff : '0;

endmodule

### hdl/indexed_list_insert_delete_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_insert_delete_unit
// Ordered list of words in a row of register cells with insert, get, delete
// and clear at a position.
// ----------------------------------------------------------------------------
// channel  dir  beat contents
// req_     in   tuser: cmd[1:0]; tdata: pos[3:0], value[35:4]
// rsp_     out  tdata: status[1:0], data_out[33:2], count[38:34]
// csr_     in   APB, capacity at 0x0
//
// One command per cycle while req_tready is high; the registered result shows in the cycle after acceptance.
// The cells at and above the position shift in the accepting cycle.
// The result register frees req_tready as soon as rsp_tready takes it.
// Reset empties the list, drops any pending result and sets capacity to 16.
// ----------------------------------------------------------------------------
module indexed_list_insert_delete_unit
   import ilid_pkg::*;
#(
   parameter int DEPTH     = 16,
   parameter int WORD_BITS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_TDATA_BITS-1:0] req_tdata,  // pos, value, pad
   input  logic [1:0]                req_tuser,  // cmd
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_TDATA_BITS-1:0] rsp_tdata,  // status, data_out, count, pad
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                      csr_pready
);

   localparam int NCELL = (DEPTH < LEN_LIMIT) ? DEPTH : LEN_LIMIT;
   localparam int SW    = (WORD_BITS < DATA_BITS) ? WORD_BITS : DATA_BITS;
   localparam logic [LEN_BITS-1:0] CAP_LIMIT = LEN_BITS'(NCELL);

   logic [LEN_BITS-1:0]  capacity_ff, capacity_in;
   logic [LEN_BITS-1:0]  len_ff, len_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [DATA_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic [LEN_BITS-1:0]  rsp_count_ff;

   logic                 accept;
   cmd_type              cmd;
   logic [LEN_BITS-1:0]  pos;
   logic [LEN_BITS-1:0]  cap_eff;
   logic [SW-1:0]        word;
   logic [SW-1:0]        read_data;
   cell_ctl_type         ctl;

   logic [SW-1:0] entry_w [NCELL];
   logic [SW-1:0] read_w  [NCELL];

   // configuration
   always_comb begin
      capacity_in = capacity_ff;
      if (csr_psel && csr_penable && csr_pwrite && (csr_paddr == CSR_CAPACITY_ADDR)) begin
         capacity_in = csr_pwdata[LEN_BITS-1:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CSR_CAPACITY_ADDR) ? CSR_DATA_BITS'(capacity_ff) : '0;

   // command decode
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign cmd        = cmd_type'(req_tuser);
   assign pos        = {1'b0, req_tdata[POS_BITS-1:0]};
   assign word       = req_tdata[POS_BITS +: SW];
   assign cap_eff    = (capacity_ff > CAP_LIMIT) ? CAP_LIMIT : capacity_ff;

   always_comb begin
      read_data = '0;
      for (int i = 0; i < NCELL; i++) begin
         read_data = read_data | read_w[i];
      end
   end

   always_comb begin
      len_in         = len_ff;
      rsp_status_in  = ST_OK;
      ctl.shift_up   = 1'b0;
      ctl.shift_down = 1'b0;
      ctl.pos        = pos;
      unique case (cmd)
         CMD_INSERT: begin
            if (len_ff >= cap_eff) begin
               rsp_status_in = ST_FULL;
            end else if (pos >= cap_eff) begin
               rsp_status_in = ST_BEYOND_CAP;
            end else begin
               ctl.shift_up = accept;
               ctl.pos      = (pos > len_ff) ? len_ff : pos;
               len_in       = len_ff + 1'b1;
            end
         end
         CMD_GET, CMD_DELETE: begin
            if (pos >= len_ff) begin
               rsp_status_in = ST_BEYOND_LEN;
            end else if (cmd == CMD_DELETE) begin
               ctl.shift_down = accept;
               len_in         = len_ff - 1'b1;
            end
         end
         CMD_CLEAR: begin
            len_in = '0;
         end
      endcase
   end

   assign rsp_data_in = ((cmd == CMD_GET || cmd == CMD_DELETE) && (rsp_status_in == ST_OK))
                        ? DATA_BITS'(read_data) : '0;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end
   end

   // cell row
   for (genvar g = 0; g < NCELL; g++) begin : g_cell
      logic [SW-1:0] left_w;
      logic [SW-1:0] right_w;
      if (g == 0) begin : g_first
         assign left_w = word;
      end else begin : g_inner
         assign left_w = entry_w[g-1];
      end
      if (g == NCELL - 1) begin : g_last
         assign right_w = entry_w[g];
      end else begin : g_body
         assign right_w = entry_w[g+1];
      end
      ilid_cell #(
         .IDX (g),
         .SW  (SW)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .word_in   (word),
         .left_in   (left_w),
         .right_in  (right_w),
         .entry_out (entry_w[g]),
         .read_out  (read_w[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CAPACITY_RESET;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         capacity_ff  <= capacity_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            len_ff <= len_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff <= rsp_status_in;
         rsp_data_ff   <= rsp_data_in;
         rsp_count_ff  <= len_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_count_ff, rsp_data_ff, rsp_status_ff};

endmodule

### hdl/ilid_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilid_checker
// Port-level checks for the indexed list insert/delete unit.
// ----------------------------------------------------------------------------
module ilid_checker
   import ilid_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic [1:0]                req_tuser,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [RSP_TDATA_BITS-1:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat changed while stalled");

   a_fail_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[1:0] != ST_OK) |-> (rsp_tdata[33:2] == '0))
      else $error("failed command returned data");

   a_clear_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == CMD_CLEAR) |=>
         rsp_tvalid && (rsp_tdata[1:0] == ST_OK) && (rsp_tdata[38:34] == '0))
      else $error("clear did not empty the list");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

endmodule

bind indexed_list_insert_delete_unit ilid_checker u_ilid_checker (.*);
